// File: rtl/wptm_pkg.sv
// Shared types and constants for the wildcard pattern trie matcher.
// No dependencies; imported by every module of the block.
`default_nettype none
package wptm_pkg;

  localparam int SymW     = 5;
  localparam int SymCount = 27;
  localparam int Wild     = 26;
  localparam int KeyW     = 20;
  localparam int IdW      = 10;
  localparam int ResMax   = 16;
  localparam int CntW     = 5;

  localparam logic [1:0] StInsDone   = 2'd0;
  localparam logic [1:0] StInsReject = 2'd1;
  localparam logic [1:0] StMatch     = 2'd2;
  localparam logic [1:0] StNoMatch   = 2'd3;

  localparam logic KindInsert = 1'b0;
  localparam logic KindQuery  = 1'b1;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_I_RD,
    S_I_CHK,
    S_I_WR,
    S_I_LEAF,
    S_I_DONE,
    S_Q_TRY,
    S_Q_CHK,
    S_Q_LEAF,
    S_Q_PUSH,
    S_Q_NEXT,
    S_Q_FIN
  } eng_state_t;

  typedef struct packed {
    logic [1:0]     status;
    logic [IdW-1:0] match_id;
    logic           last;
    logic           seen;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/wptm_front.sv
// Front end: accepts input transfers, splits the key into symbols, picks the id
// field by kind and queues commands for the engine. Depends on wptm_pkg.
`default_nettype none
module wptm_front #(
  parameter int KEY_LEN = 4
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic                                   in_kind,
  input  wire logic [wptm_pkg::KeyW-1:0]              in_key,
  input  wire logic [wptm_pkg::IdW-1:0]               in_pattern_id,
  input  wire logic [wptm_pkg::IdW-1:0]               in_target_id,
  output logic                                        cmd_valid,
  input  wire logic                                   cmd_pop,
  output logic [1+KEY_LEN*wptm_pkg::SymW+wptm_pkg::IdW-1:0] cmd
);
  import wptm_pkg::*;

  localparam int CmdW = 1 + KEY_LEN*SymW + IdW;
  localparam int WideW = 6*SymW;

  logic [CmdW-1:0] q [2];
  logic            rd_ptr;
  logic            wr_ptr;
  logic [1:0]      count;
  logic [CmdW-1:0] entry;
  logic [WideW-1:0] wide_key;
  logic [KEY_LEN*SymW-1:0] syms;
  logic            push;

  always_comb begin
    wide_key = WideW'(in_key);
    for (int i = 0; i < KEY_LEN; i++) begin
      syms[i*SymW +: SymW] = wide_key[i*SymW +: SymW];
      if (in_kind == KindInsert && wide_key[i*SymW +: SymW] > SymW'(Wild)) begin
        syms[i*SymW +: SymW] = SymW'(Wild);
      end
    end
    entry = {(in_kind == KindInsert) ? in_pattern_id : in_target_id, syms, in_kind};
  end

  assign in_ready  = (count != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (cmd_pop && cmd_valid) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(cmd_pop && cmd_valid);
    end
  end

endmodule
`default_nettype wire

// File: rtl/wptm_engine.sv
// Back end: trie memories, clearing pass, insert walk and depth-first query
// search, with the result output register. Depends on wptm_pkg.
`default_nettype none
module wptm_engine #(
  parameter int KEY_LEN    = 4,
  parameter int NODE_COUNT = 4096
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cmd_valid,
  output logic                                        cmd_pop,
  input  wire logic [1+KEY_LEN*wptm_pkg::SymW+wptm_pkg::IdW-1:0] cmd,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output wptm_pkg::res_t                              res
);
  import wptm_pkg::*;

  localparam int NW    = $clog2(NODE_COUNT);
  localparam int Links = NODE_COUNT * SymCount;
  localparam int AW    = $clog2(Links);
  localparam int DW    = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;

  eng_state_t state, state_next;

  logic [NW-1:0]  links [Links];
  logic [IdW-1:0] leafs [NODE_COUNT];
  logic [NW-1:0]  link_rdata;
  logic [IdW-1:0] leaf_rdata;

  logic [AW-1:0]  clr_addr;
  logic [KEY_LEN*SymW-1:0] syms;
  logic [IdW-1:0] cmd_id;
  logic           is_query;
  logic [DW-1:0]  d;
  logic [NW-1:0]  node;
  logic [NW-1:0]  node_stk [KEY_LEN];
  logic [KEY_LEN-1:0] br;
  logic [NW:0]    next_free;
  logic [IdW-1:0] hit;
  logic [IdW-1:0] pend;
  logic           have_pend;
  logic [CntW-1:0] cnt;
  logic           seen;
  logic           rejected;

  logic [SymW-1:0] sym_d;
  logic [SymW-1:0] sym_use;
  logic [NW-1:0]  cur_node;
  logic [AW-1:0]  link_addr;
  logic           link_we;
  logic [NW-1:0]  link_wdata;
  logic           leaf_we;
  logic [NW-1:0]  leaf_addr;
  logic           out_free;
  logic           emit;
  res_t           emit_res;
  logic           last_d;
  logic [DW:0]    needed;
  logic           pool_short;

  assign sym_d    = syms[d*SymW +: SymW];
  assign cur_node = (state == S_Q_TRY) ? node_stk[d] : node;
  assign sym_use  = (state == S_Q_TRY && br[d]) ? SymW'(Wild) : sym_d;
  assign out_free = !out_valid || out_ready;
  assign last_d   = (d == DW'(KEY_LEN-1));
  assign needed   = (DW+1)'(KEY_LEN) - (DW+1)'(d);
  assign pool_short = (NW+1)'(needed) > ((NW+1)'(NODE_COUNT) - next_free);

  // memory and output control
  always_comb begin
    link_addr  = AW'(cur_node) * AW'(SymCount) + AW'(sym_use);
    link_we    = 1'b0;
    link_wdata = NW'(next_free);
    leaf_we    = 1'b0;
    leaf_addr  = node;
    emit       = 1'b0;
    emit_res   = '0;
    cmd_pop    = 1'b0;
    case (state)
      S_CLR: begin
        link_addr  = clr_addr;
        link_we    = 1'b1;
        link_wdata = '0;
      end
      S_IDLE:   cmd_pop = cmd_valid;
      S_I_WR:   link_we = 1'b1;
      S_I_LEAF: leaf_we = 1'b1;
      S_Q_CHK:  leaf_addr = link_rdata;
      S_I_DONE: begin
        emit = out_free;
        emit_res.status = rejected ? StInsReject : StInsDone;
        emit_res.last   = 1'b1;
      end
      S_Q_PUSH: begin
        emit = out_free && have_pend && (cnt != CntW'(ResMax));
        emit_res.status   = StMatch;
        emit_res.match_id = pend;
      end
      S_Q_FIN: begin
        emit = out_free;
        emit_res.status   = have_pend ? StMatch : StNoMatch;
        emit_res.match_id = have_pend ? pend : '0;
        emit_res.last     = 1'b1;
        emit_res.seen     = have_pend && seen;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (link_we) links[link_addr] <= link_wdata;
    link_rdata <= links[link_addr];
    if (leaf_we) leafs[leaf_addr] <= cmd_id;
    leaf_rdata <= leafs[leaf_addr];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLR:  if (clr_addr == AW'(Links-1)) state_next = S_IDLE;
      S_IDLE: begin
        if (cmd_valid) state_next = cmd[0] ? S_Q_TRY : S_I_RD;
      end
      S_I_RD: state_next = S_I_CHK;
      S_I_CHK: begin
        if (link_rdata != '0) state_next = last_d ? S_I_LEAF : S_I_RD;
        else                  state_next = pool_short ? S_I_DONE : S_I_WR;
      end
      S_I_WR:   if (last_d) state_next = S_I_LEAF;
      S_I_LEAF: state_next = S_I_DONE;
      S_I_DONE: if (out_free) state_next = S_IDLE;
      S_Q_TRY: begin
        if (!br[d] && sym_d >= SymW'(Wild)) state_next = S_Q_NEXT;
        else                               state_next = S_Q_CHK;
      end
      S_Q_CHK: begin
        if (link_rdata == '0) state_next = S_Q_NEXT;
        else                  state_next = last_d ? S_Q_LEAF : S_Q_TRY;
      end
      S_Q_LEAF: state_next = S_Q_PUSH;
      S_Q_PUSH: begin
        if (cnt == CntW'(ResMax) || !have_pend || out_free) state_next = S_Q_NEXT;
      end
      S_Q_NEXT: if (br[d] && d == '0) state_next = S_Q_FIN;
                else if (!br[d]) state_next = S_Q_TRY;
      S_Q_FIN:  if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      next_free <= (NW+1)'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLR) clr_addr <= clr_addr + AW'(1);
      if (state == S_I_WR) next_free <= next_free + (NW+1)'(1);
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) res <= emit_res;
    case (state)
      S_IDLE: begin
        syms      <= cmd[KEY_LEN*SymW:1];
        cmd_id    <= cmd[KEY_LEN*SymW+IdW:KEY_LEN*SymW+1];
        is_query  <= cmd[0];
        d         <= '0;
        node      <= '0;
        node_stk[0] <= '0;
        br        <= '0;
        have_pend <= 1'b0;
        cnt       <= '0;
        seen      <= 1'b0;
        rejected  <= 1'b0;
      end
      S_I_CHK: begin
        if (link_rdata != '0) begin
          node <= link_rdata;
          if (!last_d) d <= d + DW'(1);
        end else if (pool_short) begin
          rejected <= 1'b1;
        end
      end
      S_I_WR: begin
        node <= NW'(next_free);
        if (!last_d) d <= d + DW'(1);
      end
      S_Q_CHK: begin
        if (link_rdata != '0 && !last_d) begin
          node_stk[d + DW'(1)] <= link_rdata;
          br[d + DW'(1)]       <= 1'b0;
          d                    <= d + DW'(1);
        end
      end
      S_Q_LEAF: begin
        hit <= leaf_rdata;
        if (leaf_rdata == cmd_id) seen <= 1'b1;
      end
      S_Q_PUSH: begin
        if (cnt != CntW'(ResMax) && (!have_pend || out_free)) begin
          pend      <= hit;
          have_pend <= 1'b1;
          cnt       <= cnt + CntW'(1);
        end
      end
      S_Q_NEXT: begin
        if (!br[d]) br[d] <= 1'b1;
        else if (d != '0) d <= d - DW'(1);
      end
      default: ;
    endcase
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> state == S_IDLE) else $error("command popped while busy");
  a_pool: assert property (@(posedge clk) disable iff (rst)
    next_free <= (NW+1)'(NODE_COUNT)) else $error("node pool overrun");
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.status != StMatch |-> res.last) else $error("non-match not last");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE && state != S_CLR && is_query |-> cnt <= CntW'(ResMax))
    else $error("result count overflow");

endmodule
`default_nettype wire

// File: rtl/wildcard_pattern_trie_match.sv
// Wildcard pattern trie matcher, top level: input stream, front queue, engine.
// Depends on wptm_pkg, wptm_front and wptm_engine.
// After reset the block clears its child-link memory; the front queue takes at
// most two transfers meanwhile.
// An insert reads the child link at each trie level, writes a new node where a
// link is missing, then writes the leaf id and reports; a rejected insert, short
// of free nodes, reports without writing. A query walks up to 2^(KEY_LEN+1)-2
// child links depth first, exact symbol before wildcard, reading each leaf and
// switching branch and backtracking at branch points; it reports each match.
// The child-link memory is single-ported with a registered read.
// A two-entry command queue and the output register let input and output
// stall independently.
`default_nettype none
module wildcard_pattern_trie_match #(
  parameter int KEY_LEN    = 4,
  parameter int NODE_COUNT = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // key[19:0], pattern_id[29:20], target_id[39:30]
  input  wire logic        s_axis_tuser,  // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // match_id[9:0], target_seen[10], zero fill
  output logic [1:0]       m_axis_tuser,  // status
  output logic             m_axis_tlast   // is_last
);
  import wptm_pkg::*;

  localparam int CmdW = 1 + KEY_LEN*SymW + IdW;

  logic            cmd_valid;
  logic            cmd_pop;
  logic [CmdW-1:0] cmd;
  res_t            res;

  wptm_front #(.KEY_LEN(KEY_LEN)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_kind(s_axis_tuser), .in_key(s_axis_tdata[19:0]),
    .in_pattern_id(s_axis_tdata[29:20]), .in_target_id(s_axis_tdata[39:30]),
    .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd)
  );

  wptm_engine #(.KEY_LEN(KEY_LEN), .NODE_COUNT(NODE_COUNT)) u_engine (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .res(res)
  );

  assign m_axis_tdata = {5'd0, res.seen, res.match_id};
  assign m_axis_tuser = res.status;
  assign m_axis_tlast = res.last;

endmodule
`default_nettype wire

// File: bench/wptm_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for the wildcard pattern trie matcher: tracks its own trie copy,
// predicts results per input transfer and compares output transfers. Uses wptm_pkg.
module wptm_scoreboard #(
  parameter int KEY_LEN    = 4,
  parameter int NODE_COUNT = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,
  input  wire logic        s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [15:0] m_axis_tdata,
  input  wire logic [1:0]  m_axis_tuser,
  input  wire logic        m_axis_tlast,
  output int               fails,
  output int               pending
);
  import wptm_pkg::*;

  logic [12:0]    trie_links [NODE_COUNT*SymCount];
  logic [IdW-1:0] leaf_id [NODE_COUNT];
  int unsigned    nodes_used;
  res_t           match_q[$];

  function automatic res_t mk_res(logic [1:0] st, logic [IdW-1:0] id, logic lst, logic sn);
    res_t r;
    r.status = st;
    r.match_id = id;
    r.last = lst;
    r.seen = sn;
    return r;
  endfunction

  task automatic insert_pattern(logic [KeyW-1:0] key, logic [IdW-1:0] id);
    int unsigned node;
    int unsigned missing;
    int unsigned s;
    int unsigned slot;
    node = 0;
    missing = 0;
    for (int d = 0; d < KEY_LEN; d++) begin
      s = (key >> (SymW*d)) & 31;
      if (s > Wild) s = Wild;
      if (missing == 0 && trie_links[node*SymCount+s] != 0)
        node = 32'(trie_links[node*SymCount+s]);
      else missing++;
    end
    if (missing > NODE_COUNT - nodes_used) begin
      match_q = {match_q, mk_res(StInsReject, '0, 1'b1, 1'b0)};
    end else begin
      node = 0;
      for (int d = 0; d < KEY_LEN; d++) begin
        s = (key >> (SymW*d)) & 31;
        if (s > Wild) s = Wild;
        slot = node*SymCount + s;
        if (trie_links[slot] == 0) begin
          trie_links[slot] = 13'(nodes_used);
          leaf_id[nodes_used] = '0;
          nodes_used++;
        end
        node = 32'(trie_links[slot]);
      end
      leaf_id[node] = id;
      match_q = {match_q, mk_res(StInsDone, '0, 1'b1, 1'b0)};
    end
  endtask

  task automatic query_key(logic [KeyW-1:0] key, logic [IdW-1:0] target);
    logic [IdW-1:0] hits[$];
    logic           hit_target;
    int unsigned    node;
    int unsigned    s;
    bit             alive;
    bit             wild;
    hit_target = 1'b0;
    for (int p = 0; p < (1 << KEY_LEN); p++) begin
      node = 0;
      alive = 1;
      for (int d = 0; d < KEY_LEN && alive; d++) begin
        wild = p[KEY_LEN-1-d];
        s = wild ? Wild : ((key >> (SymW*d)) & 31);
        if (!wild && s >= Wild) alive = 0;
        else begin
          node = 32'(trie_links[node*SymCount+s]);
          if (node == 0) alive = 0;
        end
      end
      if (alive) begin
        if (leaf_id[node] == target) hit_target = 1'b1;
        if (hits.size() < ResMax) hits = {hits, leaf_id[node]};
      end
    end
    if (hits.size() == 0) match_q = {match_q, mk_res(StNoMatch, '0, 1'b1, 1'b0)};
    else
      foreach (hits[k])
        match_q = {match_q, mk_res(StMatch, hits[k], k == hits.size()-1,
                                   (k == hits.size()-1) ? hit_target : 1'b0)};
  endtask

  initial begin
    fails = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      foreach (trie_links[i]) trie_links[i] = '0;
      foreach (leaf_id[i]) leaf_id[i] = '0;
      nodes_used = 1;
      match_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = mk_res(m_axis_tuser, m_axis_tdata[9:0], m_axis_tlast, m_axis_tdata[10]);
        if (match_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result transfer: %p", got);
        end else begin
          want = match_q.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == KindInsert) insert_pattern(s_axis_tdata[19:0], s_axis_tdata[29:20]);
        else query_key(s_axis_tdata[19:0], s_axis_tdata[39:30]);
      end
    end
    pending = match_q.size();
  end

endmodule

// File: bench/tb_wildcard_pattern_trie_match.sv
`timescale 1ns / 1ps
// Testbench top for wildcard_pattern_trie_match: clock, reset, stimulus, verdict.
// Depends on wptm_pkg, the block and wptm_scoreboard.
module tb_wildcard_pattern_trie_match;
  import wptm_pkg::*;

  localparam int KEY_LEN    = 4;
  localparam int NODE_COUNT = 256;
  localparam int CYCLE_LIMIT = 1000000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  int          fails;
  int          pending;
  int          cycles;
  bit          quiet;
  int          sink_stall;
  logic [IdW-1:0] ids_loaded[$];

  wildcard_pattern_trie_match #(.KEY_LEN(KEY_LEN), .NODE_COUNT(NODE_COUNT)) u_top (.*);

  wptm_scoreboard #(.KEY_LEN(KEY_LEN), .NODE_COUNT(NODE_COUNT)) u_sb (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("FAIL wildcard_pattern_trie_match");
        $finish;
      end
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    sink_stall = 0;
    forever begin
      @(posedge clk);
      if (quiet) m_axis_tready <= 1'b1;
      else if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 12) begin
        sink_stall = $urandom_range(0, 14);
        m_axis_tready <= 1'b0;
      end else m_axis_tready <= 1'b1;
    end
  end

  task automatic send(logic kind, logic [KeyW-1:0] key, logic [IdW-1:0] pid,
                      logic [IdW-1:0] tid);
    if (!quiet && $urandom_range(0, 99) < 20) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {tid, pid, key};
    if (kind == KindInsert) ids_loaded = {ids_loaded, pid};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic logic [SymW-1:0] rand_sym();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return SymW'($urandom_range(0, 2));
    if (r < 85) return SymW'(Wild);
    if (r < 95) return SymW'($urandom_range(27, 31));
    return SymW'($urandom_range(0, 25));
  endfunction

  function automatic logic [KeyW-1:0] rand_key();
    logic [KeyW-1:0] k;
    for (int d = 0; d < KEY_LEN; d++) k[SymW*d +: SymW] = rand_sym();
    return k;
  endfunction

  initial begin
    logic [KeyW-1:0] k;
    logic [IdW-1:0]  tid;
    rst = 1'b1;
    quiet = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = KindInsert;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty trie, then every a/wildcard combination, then overlapping walks
    send(KindQuery, 20'h0, '0, 10'd0);
    send(KindInsert, 20'h0, 10'd0, '0);
    for (int p = 0; p < 16; p++) begin
      for (int d = 0; d < KEY_LEN; d++) k[SymW*d +: SymW] = p[d] ? SymW'(Wild) : 5'd0;
      send(KindInsert, k, 10'd1000 + p[9:0], '0);
    end
    send(KindQuery, 20'h0, '0, 10'd1015);
    send(KindQuery, 20'hFFFFF, '0, 10'd7);
    send(KindInsert, 20'hFFFFF, 10'd1023, '0);
    send(KindQuery, {4{5'd1}}, '0, 10'd1023);
    send(KindQuery, {4{5'd25}}, '0, 10'd0);

    for (int i = 0; i < 230; i++) begin
      if (i == 100) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
      end
      if (i == 200) quiet = 1'b1;
      k = ($urandom_range(0, 19) == 0) ? 20'($urandom) : rand_key();
      if ($urandom_range(0, 99) < 40) send(KindInsert, k, 10'($urandom), 10'($urandom));
      else begin
        tid = ($urandom_range(0, 1) && ids_loaded.size() > 0) ?
              ids_loaded[$urandom_range(0, ids_loaded.size()-1)] : 10'($urandom);
        send(KindQuery, k, 10'($urandom), tid);
      end
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk);

    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (fails == 0 && pending == 0) $display("PASS wildcard_pattern_trie_match");
    else $display("FAIL wildcard_pattern_trie_match");
    $finish;
  end

endmodule

// File: sim.f
rtl/wptm_pkg.sv
rtl/wptm_front.sv
rtl/wptm_engine.sv
rtl/wildcard_pattern_trie_match.sv
bench/wptm_scoreboard.sv
bench/tb_wildcard_pattern_trie_match.sv
